@@ rtl/core/ats_pkg.sv @@
`timescale 1ns / 1ps

package ats_pkg;

  localparam int unsigned MAX_DEPTH   = 3;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned STACK_DEPTH = 3 * MAX_DEPTH + 1;
  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FACE_W      = 9 * 32;
  localparam int unsigned ENTRY_W     = FACE_W + LEVEL_W;

  typedef logic [2:0][31:0] vertex_t;
  // index 0..2 vertex a, 3..5 vertex b, 6..8 vertex c
  typedef logic [8:0][31:0] face_t;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_a_x;
    logic signed [31:0] out_a_y;
    logic signed [31:0] out_a_z;
    logic signed [31:0] out_b_x;
    logic signed [31:0] out_b_y;
    logic signed [31:0] out_b_z;
    logic signed [31:0] out_c_x;
    logic signed [31:0] out_c_y;
    logic signed [31:0] out_c_z;
    logic               last_face;
    logic               depth_overflow;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic fits;
  } area_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TEST,
    ST_EMIT,
    ST_SPLIT,
    ST_POP,
    ST_FETCH
  } state_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_P1,
    OP_P2,
    OP_SLL,
    OP_SHL,
    OP_SHH,
    OP_RLL,
    OP_RHL,
    OP_RHH
  } op_e;

  // Keep the low COORD_W bits and sign-extend them back to 32.
  function automatic logic [31:0] sext_coord(input logic [31:0] raw);
    logic [31:0] res;
    res = {32{raw[COORD_W-1]}};
    res[COORD_W-1:0] = raw[COORD_W-1:0];
    return res;
  endfunction

  // floor((p + q) / 2)
  function automatic logic [31:0] mid(input logic [31:0] p, input logic [31:0] q);
    logic signed [32:0] s;
    s = $signed({p[31], p}) + $signed({q[31], q});
    return s[32:1];
  endfunction

endpackage

@@ rtl/core/ats_if.sv @@
`timescale 1ns / 1ps

interface ats_in_if import ats_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ats_out_if import ats_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/ats_ram.sv @@
`timescale 1ns / 1ps

module ats_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ats_area.sv @@
`timescale 1ns / 1ps

// Area test: |(b-a) x (c-a)|^2 <= 4 * max_area^2, one shared 34x34 multiplier.
module ats_area import ats_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  face_t     face_i,
  input  logic [63:0] max_area_i,
  output area_res_t res_o
);

  localparam int unsigned ACC_W = 132;

  logic               busy_q;
  logic [1:0]         comp_q;
  logic [2:0]         phase_q;
  logic signed [32:0] u_q [3];
  logic signed [32:0] w_q [3];
  logic [67:0]        prod_q;
  logic               neg_q;
  op_e                tag_q;
  logic signed [66:0] p1_q;
  logic [65:0]        d_q;
  logic [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]   rhs_q;

  op_e                op;
  logic signed [32:0] x1, y1, x2, y2;
  logic [33:0]        ma, mb;
  logic               neg;
  logic signed [66:0] sprod;
  logic signed [66:0] diff;
  logic               last_step;

  function automatic logic [33:0] mag33(input logic signed [32:0] x);
    logic [32:0] m;
    m = x[32] ? 33'(-x) : 33'(x);
    return {1'b0, m};
  endfunction

  always_comb begin
    unique case (comp_q)
      2'd0:    begin x1 = u_q[1]; y1 = w_q[2]; x2 = u_q[2]; y2 = w_q[1]; end
      2'd1:    begin x1 = u_q[2]; y1 = w_q[0]; x2 = u_q[0]; y2 = w_q[2]; end
      default: begin x1 = u_q[0]; y1 = w_q[1]; x2 = u_q[1]; y2 = w_q[0]; end
    endcase

    op = OP_NOP;
    if (busy_q) begin
      if (comp_q == 2'd3) begin
        unique case (phase_q)
          3'd0:    op = OP_RLL;
          3'd1:    op = OP_RHL;
          3'd2:    op = OP_RHH;
          default: op = OP_NOP;
        endcase
      end else begin
        unique case (phase_q)
          3'd0:    op = OP_P1;
          3'd1:    op = OP_P2;
          3'd3:    op = OP_SLL;
          3'd4:    op = OP_SHL;
          3'd5:    op = OP_SHH;
          default: op = OP_NOP;
        endcase
      end
    end

    neg = 1'b0;
    unique case (op)
      OP_P1:   begin ma = mag33(x1); mb = mag33(y1); neg = x1[32] ^ y1[32]; end
      OP_P2:   begin ma = mag33(x2); mb = mag33(y2); neg = x2[32] ^ y2[32]; end
      OP_SLL:  begin ma = d_q[33:0]; mb = d_q[33:0]; end
      OP_SHL:  begin ma = {2'b00, d_q[65:34]}; mb = d_q[33:0]; end
      OP_SHH:  begin ma = {2'b00, d_q[65:34]}; mb = {2'b00, d_q[65:34]}; end
      OP_RLL:  begin ma = {2'b00, max_area_i[31:0]}; mb = {2'b00, max_area_i[31:0]}; end
      OP_RHL:  begin ma = {2'b00, max_area_i[63:32]}; mb = {2'b00, max_area_i[31:0]}; end
      OP_RHH:  begin ma = {2'b00, max_area_i[63:32]}; mb = {2'b00, max_area_i[63:32]}; end
      default: begin ma = '0; mb = '0; end
    endcase

    sprod = neg_q ? 67'(0) - $signed({2'b00, prod_q[64:0]}) : $signed({2'b00, prod_q[64:0]});
    diff  = p1_q - sprod;
    last_step = busy_q && (comp_q == 2'd3) && (phase_q == 3'd4);
  end

  assign res_o.done = last_step;
  assign res_o.fits = (acc_q <= rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      comp_q  <= '0;
      phase_q <= '0;
      tag_q   <= OP_NOP;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      comp_q  <= '0;
      phase_q <= '0;
      tag_q   <= OP_NOP;
    end else if (busy_q) begin
      tag_q <= op;
      if (last_step) begin
        busy_q <= 1'b0;
      end else if (comp_q != 2'd3 && phase_q == 3'd5) begin
        comp_q  <= comp_q + 2'd1;
        phase_q <= '0;
      end else begin
        phase_q <= phase_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= $signed({face_i[3+i][31], face_i[3+i]}) - $signed({face_i[i][31], face_i[i]});
        w_q[i] <= $signed({face_i[6+i][31], face_i[6+i]}) - $signed({face_i[i][31], face_i[i]});
      end
      acc_q <= '0;
      rhs_q <= '0;
    end else begin
      prod_q <= ma * mb;
      neg_q  <= neg;
      unique case (tag_q)
        OP_P1:   p1_q  <= sprod;
        OP_P2:   d_q   <= diff[66] ? 66'(-diff) : 66'(diff);
        OP_SLL:  acc_q <= acc_q + ACC_W'(prod_q);
        OP_SHL:  acc_q <= acc_q + (ACC_W'(prod_q) << 35);
        OP_SHH:  acc_q <= acc_q + (ACC_W'(prod_q) << 68);
        OP_RLL:  rhs_q <= rhs_q + (ACC_W'(prod_q) << 2);
        OP_RHL:  rhs_q <= rhs_q + (ACC_W'(prod_q) << 35);
        OP_RHH:  rhs_q <= rhs_q + (ACC_W'(prod_q) << 66);
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/adaptive_triangle_subdivider.sv @@
`timescale 1ns / 1ps

// Adaptive triangle subdivider.
// in_i takes one triangle request (nine Q16.16 coordinates); out_o returns the
// emitted faces of that triangle in depth-first order, last_face high on the
// final one and depth_overflow high on a face emitted at the depth limit while
// still too large. cfg_we_i/cfg_wdata_i write max_area (Q32.32) while idle.
// Only one triangle is handled at a time; in_i.ready is high only in idle. Every
// tested face passes one load state and then the area unit, which runs 18
// multiply steps through one shared 34x34 multiplier. A split writes one stack
// entry for each of the three pushed sub-faces, a stack pop passes ST_POP and
// ST_FETCH (registered read), and an emit waits in ST_EMIT for out_o.ready.
// A full split to depth 3 tests 85 faces and emits 64.
// Reset clears the sequencer and the stack pointer and sets max_area to all
// ones; the stack memory itself is not cleared. A stalled receiver holds the
// block in the emit state with the face stable until out_o.ready rises.
module adaptive_triangle_subdivider import ats_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ats_in_if.sink      in_i,
  ats_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i
);

  state_e              state_q, state_d;
  face_t               face_q, face_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [1:0]          push_q, push_d;
  logic                ovf_q, ovf_d;
  logic [63:0]         max_area_q;

  vertex_t             va, vb, vc, p0, p1, p2;
  area_res_t           area_res;
  logic                area_start;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [SP_W-1:0]     ram_raddr;
  in_item_t            in_data;

  assign in_data = in_i.data;

  // Split the current face at its edge midpoints.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = face_q[i];
      vb[i] = face_q[3+i];
      vc[i] = face_q[6+i];
      p0[i] = mid(face_q[i], face_q[3+i]);
      p1[i] = mid(face_q[3+i], face_q[6+i]);
      p2[i] = mid(face_q[i], face_q[6+i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sp_q       <= '0;
      push_q     <= '0;
      max_area_q <= '1;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      push_q  <= push_d;
      if (cfg_we_i) begin
        max_area_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    face_q  <= face_d;
    level_q <= level_d;
    ovf_q   <= ovf_d;
  end

  always_comb begin
    state_d    = state_q;
    face_d     = face_q;
    level_d    = level_q;
    sp_d       = sp_q;
    push_d     = push_q;
    ovf_d      = ovf_q;
    area_start = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    ram_raddr  = sp_q - SP_W'(1);
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          face_d = {sext_coord(in_data.c_z), sext_coord(in_data.c_y), sext_coord(in_data.c_x),
                    sext_coord(in_data.b_z), sext_coord(in_data.b_y), sext_coord(in_data.b_x),
                    sext_coord(in_data.a_z), sext_coord(in_data.a_y), sext_coord(in_data.a_x)};
          level_d = '0;
          sp_d    = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        area_start = 1'b1;
        state_d    = ST_TEST;
      end
      ST_TEST: begin
        if (area_res.done) begin
          ovf_d  = !area_res.fits;
          push_d = '0;
          if (area_res.fits || level_q == LEVEL_W'(MAX_DEPTH)) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SPLIT;
          end
        end
      end
      ST_EMIT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          state_d = (sp_q == '0) ? ST_IDLE : ST_POP;
        end
      end
      ST_SPLIT: begin
        // Push the three later sub-faces deepest first; keep the first one.
        ram_we = 1'b1;
        unique case (push_q)
          2'd0:    ram_wdata = {level_q + LEVEL_W'(1), p1, p0, p2};
          2'd1:    ram_wdata = {level_q + LEVEL_W'(1), vc, p1, p2};
          default: ram_wdata = {level_q + LEVEL_W'(1), p1, vb, p0};
        endcase
        sp_d   = sp_q + SP_W'(1);
        push_d = push_q + 2'd1;
        if (push_q == 2'd2) begin
          face_d  = {p2, p0, va};
          level_d = level_q + LEVEL_W'(1);
          state_d = ST_LOAD;
        end
      end
      ST_POP: begin
        sp_d    = sp_q - SP_W'(1);
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        face_d  = ram_rdata[FACE_W-1:0];
        level_d = ram_rdata[ENTRY_W-1:FACE_W];
        state_d = ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_o.data.out_a_x        = face_q[0];
  assign out_o.data.out_a_y        = face_q[1];
  assign out_o.data.out_a_z        = face_q[2];
  assign out_o.data.out_b_x        = face_q[3];
  assign out_o.data.out_b_y        = face_q[4];
  assign out_o.data.out_b_z        = face_q[5];
  assign out_o.data.out_c_x        = face_q[6];
  assign out_o.data.out_c_y        = face_q[7];
  assign out_o.data.out_c_z        = face_q[8];
  assign out_o.data.last_face      = (sp_q == '0);
  assign out_o.data.depth_overflow = ovf_q;

  ats_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH),
    .ADDR_W(SP_W)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(sp_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ats_area u_area (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (area_start),
    .face_i    (face_q),
    .max_area_i(max_area_q),
    .res_o     (area_res)
  );

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH - 1))
    else $error("stack pointer beyond stack depth");

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> state_q == ST_LOAD)
    else $error("accepted request did not start a test");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.last_face) |=> state_q == ST_IDLE)
    else $error("block not idle after last face");

  a_done_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    area_res.done |-> state_q == ST_TEST)
    else $error("area result outside test state");
`endif

endmodule

@@ sim/tb_adaptive_triangle_subdivider.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the adaptive triangle subdivider.
// A table of directed triangle requests runs first, then random requests.
// Every accepted request goes through a local subdivision predictor; emitted
// faces are queued and compared field by field as out_o delivers them.
module tb_adaptive_triangle_subdivider;
  import ats_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TREE_DEPTH = 3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;

  ats_in_if  tri_if ();
  ats_out_if face_if ();

  adaptive_triangle_subdivider DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tri_if),
    .out_o      (face_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Directed table row: a triangle, the area limit to load first, and an
  // optional typed-in expected face (only where the answer is obvious).
  typedef struct {
    in_item_t  stim;
    logic [63:0] area;
    bit        has_face;
    out_item_t face;
  } tri_row_t;

  out_item_t   face_q[$];
  logic [63:0] area_limit;
  int unsigned err_count;
  int unsigned cycle_count;
  bit          fail_seen;
  bit          last_ack;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Run guard: declare failure if the bench never finishes.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Exact doubled-area-squared test: |u x w|^2 <= 4 * max_area^2.
  function automatic bit face_fits(input logic signed [31:0] v[9]);
    logic signed [33:0] ux, uy, uz, wx, wy, wz;
    logic signed [67:0] cx, cy, cz;
    logic [135:0] lhs;
    logic [135:0] rhs;
    ux = v[3] - v[0]; uy = v[4] - v[1]; uz = v[5] - v[2];
    wx = v[6] - v[0]; wy = v[7] - v[1]; wz = v[8] - v[2];
    cx = uy * wz - uz * wy;
    cy = uz * wx - ux * wz;
    cz = ux * wy - uy * wx;
    lhs = 136'(cx * cx) + 136'(cy * cy) + 136'(cz * cz);
    rhs = (136'(area_limit) * 136'(area_limit)) << 2;
    return lhs <= rhs;
  endfunction

  function automatic logic signed [31:0] half_sum(input logic signed [31:0] p,
                                                 input logic signed [31:0] q);
    logic signed [32:0] s;
    s = 33'(p) + 33'(q);
    return s[32:1];
  endfunction

  // Depth-first walk of the split tree; queue each emitted face.
  task automatic predict_faces(input in_item_t t);
    logic signed [31:0] stk[16][9];
    int unsigned lvl[16];
    int sp;
    logic signed [31:0] v[9];
    logic signed [31:0] p0[3], p1[3], p2[3];
    int unsigned l;
    bit fits;
    out_item_t f;
    sp = 1;
    stk[0] = '{t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z};
    lvl[0] = 0;
    while (sp > 0) begin
      sp--;
      v = stk[sp];
      l = lvl[sp];
      fits = face_fits(v);
      if (fits || l >= TREE_DEPTH) begin
        f = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
              (sp == 0), !fits};
        face_q = {face_q, f};
      end else begin
        for (int i = 0; i < 3; i++) begin
          p0[i] = half_sum(v[i], v[3+i]);
          p1[i] = half_sum(v[3+i], v[6+i]);
          p2[i] = half_sum(v[i], v[6+i]);
        end
        // push in reverse so (a,p0,p2) pops first
        stk[sp] = '{p2[0], p2[1], p2[2], p0[0], p0[1], p0[2], p1[0], p1[1], p1[2]};
        lvl[sp++] = l + 1;
        stk[sp] = '{p2[0], p2[1], p2[2], p1[0], p1[1], p1[2], v[6], v[7], v[8]};
        lvl[sp++] = l + 1;
        stk[sp] = '{p0[0], p0[1], p0[2], v[3], v[4], v[5], p1[0], p1[1], p1[2]};
        lvl[sp++] = l + 1;
        stk[sp] = '{v[0], v[1], v[2], p0[0], p0[1], p0[2], p2[0], p2[1], p2[2]};
        lvl[sp++] = l + 1;
      end
    end
  endtask

  // Receiver: random stalls drawn per face, compare against the oldest face.
  initial begin
    int unsigned stall;
    out_item_t want;
    face_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      // drop ready only for a drawn stall, so every accepted face is checked
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        face_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      face_if.ready <= 1'b1;
      do @(posedge clk_i); while (!face_if.valid);
      if (face_q.size() == 0) begin
        report_mismatch("face with no request waiting");
      end else begin
        want = face_q.pop_front();
        if (face_if.data.out_a_x !== want.out_a_x) report_mismatch("out_a_x");
        if (face_if.data.out_a_y !== want.out_a_y) report_mismatch("out_a_y");
        if (face_if.data.out_a_z !== want.out_a_z) report_mismatch("out_a_z");
        if (face_if.data.out_b_x !== want.out_b_x) report_mismatch("out_b_x");
        if (face_if.data.out_b_y !== want.out_b_y) report_mismatch("out_b_y");
        if (face_if.data.out_b_z !== want.out_b_z) report_mismatch("out_b_z");
        if (face_if.data.out_c_x !== want.out_c_x) report_mismatch("out_c_x");
        if (face_if.data.out_c_y !== want.out_c_y) report_mismatch("out_c_y");
        if (face_if.data.out_c_z !== want.out_c_z) report_mismatch("out_c_z");
        if (face_if.data.last_face !== want.last_face) report_mismatch("last_face");
        if (face_if.data.depth_overflow !== want.depth_overflow)
          report_mismatch("depth_overflow");
      end
    end
  end

  // Load max_area only while nothing is in flight.
  task automatic write_area(input logic [63:0] val);
    tri_if.valid <= 1'b0;
    wait (face_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    area_limit = val;
  endtask

  // Send one triangle request after a random gap, predict on acceptance.
  // Valid stays high after acceptance until the next gap or pause; the block
  // keeps ready low after it accepts until it is back in idle.
  task automatic send_tri(input in_item_t t);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      tri_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tri_if.valid <= 1'b1;
    tri_if.data  <= t;
    do @(posedge clk_i); while (!tri_if.ready);
    predict_faces(t);
  endtask

  function automatic logic [31:0] rand_coord(input int unsigned span);
    case (span)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 'h3_0000)) - 'h1_8000);
      default: return 32'($signed($urandom_range(0, 'h40)) - 'h20);
    endcase
  endfunction

  function automatic in_item_t rand_tri(input int unsigned span);
    in_item_t t;
    t = '{rand_coord(span), rand_coord(span), rand_coord(span),
          rand_coord(span), rand_coord(span), rand_coord(span),
          rand_coord(span), rand_coord(span), rand_coord(span)};
    return t;
  endfunction

  function automatic out_item_t whole_face(input in_item_t t, input bit ovf);
    return '{t.a_x, t.a_y, t.a_z, t.b_x, t.b_y, t.b_z, t.c_x, t.c_y, t.c_z,
             1'b1, ovf};
  endfunction

  initial begin
    tri_row_t rows[$];
    tri_row_t r;
    in_item_t t;
    logic [63:0] areas[6];
    logic signed [31:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    err_count   = 0;
    area_limit  = '1;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    tri_if.valid = 1'b0;
    tri_if.data  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Degenerate: zero area, emitted unchanged even with a zero limit.
    r.stim = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; r.area = '0; r.has_face = 1;
    r.face = whole_face(r.stim, 0); rows = {rows, r};
    r.stim = '{mx, mn, mx, mx, mn, mx, mx, mn, mx}; r.area = '0;
    r.face = whole_face(r.stim, 0); rows = {rows, r};
    // Unit triangle at the reset limit: fits, one face.
    r.stim = '{0, 0, 0, 'h1_0000, 0, 0, 0, 'h1_0000, 0}; r.area = '1;
    r.face = whole_face(r.stim, 0); rows = {rows, r};
    // Huge triangles: they still fit at the all-ones limit, one face each.
    r.has_face = 0;
    r.stim = '{mn, mn, mn, mx, mn, mx, mn, mx, mx}; r.area = '1; rows = {rows, r};
    r.stim = '{mn, mn, 0, mx, mx, 0, mn, mx, 0}; r.area = '1; rows = {rows, r};
    // Zero limit on a real triangle: full split, overflow faces at depth 3,
    // odd coordinates exercise midpoint rounding toward minus infinity.
    r.stim = '{-3, -1, 5, 7, -9, 1, -5, 3, -7}; r.area = '0; rows = {rows, r};
    r.stim = '{mn, 1, -1, mx, -1, 1, 0, mx, mn}; r.area = '0; rows = {rows, r};
    r.stim = '{0, 0, 0, 'h4_0000, 0, 0, 0, 'h4_0000, 0}; r.area = 64'h1_0000_0000;
    rows = {rows, r};
    r.stim = '{0, 0, 0, 'h4_0000, 0, 0, 0, 'h4_0000, 0}; r.area = 64'h8_0000_0000;
    rows = {rows, r};
    r.stim = '{mx, mx, mx, mn, mn, mn, 'h5555_5555, 'haaaa_aaaa, 0}; r.area = '1;
    rows = {rows, r};

    foreach (rows[i]) begin
      if (rows[i].area !== area_limit) write_area(rows[i].area);
      if (rows[i].has_face) begin
        t = rows[i].stim;
        send_tri(t);
        // typed-in answer must agree with the predictor's single face
        if (face_q.size() != 1 || face_q[0] !== rows[i].face)
          report_mismatch("directed face differs from typed-in answer");
      end else begin
        send_tri(rows[i].stim);
      end
    end

    // Random phases over several limits, extremes included.
    areas = '{64'hffff_ffff_ffff_ffff, 64'h0, 64'h1_0000_0000,
              64'h0000_0040_0000_0000, 64'h0000_0000_0100_0000, 64'h1};
    foreach (areas[p]) begin
      write_area(areas[p]);
      for (int n = 0; n < 25; n++) begin
        send_tri(rand_tri($urandom_range(0, 2)));
        // let the pipeline drain completely once per phase
        if (n == 12) begin
          tri_if.valid <= 1'b0;
          wait (face_q.size() == 0);
        end
      end
    end

    tri_if.valid <= 1'b0;
    wait (face_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
